>>> src/gfl_pkg.sv
`default_nettype none
package gfl_pkg;

    localparam int GLYPH_COUNT = 95;
    localparam int GIDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int Q_DEPTH = 4;

    localparam logic [7:0] CHAR_FIRST   = 8'd32;
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_START  = 2'd1;
    localparam logic [1:0] OP_CHAR   = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    localparam logic RK_BLIT = 1'b0;
    localparam logic RK_DIMS = 1'b1;

    typedef enum logic [1:0] {
        K_START,
        K_NEWLINE,
        K_GLYPH,
        K_FINISH
    } t_kind;

    typedef struct packed {
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic [11:0] src_w;
        logic [11:0] src_h;
        logic [10:0] off_x;
        logic [10:0] off_y;
        logic [9:0]  adv;
    } t_glyph;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [27:0] prod_x;
        logic [27:0] prod_y;
        logic [17:0] adv_step;
        logic [11:0] src_x;
        logic [11:0] src_y;
        logic [11:0] src_w;
        logic [11:0] src_h;
    } t_cmd;

    typedef struct packed {
        logic [15:0] scale;
        logic [17:0] line_step;
        logic        draw_en;
        logic [31:0] tint;
    } t_cfg;

endpackage
`default_nettype wire

>>> src/gfl_in_if.sv
`default_nettype none
interface gfl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [11:0] glyph_src_x;
    logic [11:0] glyph_src_y;
    logic [11:0] glyph_width;
    logic [11:0] glyph_height;
    logic [10:0] glyph_off_x;
    logic [10:0] glyph_off_y;
    logic [9:0]  glyph_advance;

    modport source (
        output valid, operation, char_code, pos_x, pos_y, glyph_src_x, glyph_src_y,
               glyph_width, glyph_height, glyph_off_x, glyph_off_y, glyph_advance,
        input  ready
    );
    modport sink (
        input  valid, operation, char_code, pos_x, pos_y, glyph_src_x, glyph_src_y,
               glyph_width, glyph_height, glyph_off_x, glyph_off_y, glyph_advance,
        output ready
    );
endinterface
`default_nettype wire

>>> src/gfl_out_if.sv
`default_nettype none
interface gfl_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [23:0] dest_x;
    logic [23:0] dest_y;
    logic [11:0] src_x;
    logic [11:0] src_y;
    logic [11:0] src_w;
    logic [11:0] src_h;
    logic [31:0] blit_color;
    logic [16:0] text_width;
    logic [16:0] text_height;

    modport source (
        output valid, result_kind, dest_x, dest_y, src_x, src_y, src_w, src_h,
               blit_color, text_width, text_height,
        input  ready
    );
    modport sink (
        input  valid, result_kind, dest_x, dest_y, src_x, src_y, src_w, src_h,
               blit_color, text_width, text_height,
        output ready
    );
endinterface
`default_nettype wire

>>> src/gfl_front.sv
`default_nettype none
module gfl_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    gfl_in_if.sink             s_in,
    input  wire gfl_pkg::t_cfg i_cfg,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output gfl_pkg::t_cmd      o_q_data
);
    import gfl_pkg::*;

    t_glyph              r_mem [GLYPH_COUNT];
    t_glyph              r_rd;
    logic                r_s1_valid;
    t_kind               r_s1_kind;
    logic [15:0]         r_s1_pos_x;
    logic [15:0]         r_s1_pos_y;

    logic                accept;
    logic                has_cmd;
    t_kind               kind;
    logic                load_ok;
    logic                glyph_ok;
    logic [8:0]          rel;
    logic [GIDX_W-1:0]   rd_idx;
    logic [GIDX_W-1:0]   wr_idx;
    t_glyph              wr_data;
    logic signed [27:0]  prod_x;
    logic signed [27:0]  prod_y;
    logic [25:0]         adv_prod;

    assign o_q_push   = r_s1_valid && !i_q_full;
    assign s_in.ready = !r_s1_valid || o_q_push;
    assign accept     = s_in.valid && s_in.ready;

    assign rel      = {1'b0, s_in.char_code} - {1'b0, CHAR_FIRST};
    assign glyph_ok = (s_in.char_code >= CHAR_FIRST) && (rel < 9'(GLYPH_COUNT));
    assign load_ok  = {1'b0, s_in.char_code} < 9'(GLYPH_COUNT);
    assign rd_idx   = rel[GIDX_W-1:0];
    assign wr_idx   = s_in.char_code[GIDX_W-1:0];

    assign wr_data = '{
        src_x: s_in.glyph_src_x,
        src_y: s_in.glyph_src_y,
        src_w: s_in.glyph_width,
        src_h: s_in.glyph_height,
        off_x: s_in.glyph_off_x,
        off_y: s_in.glyph_off_y,
        adv:   s_in.glyph_advance
    };

    always_comb begin
        has_cmd = 1'b0;
        kind    = K_START;
        case (s_in.operation)
            OP_START: begin
                has_cmd = 1'b1;
                kind    = K_START;
            end
            OP_FINISH: begin
                has_cmd = 1'b1;
                kind    = K_FINISH;
            end
            OP_CHAR: begin
                if (s_in.char_code == CHAR_NEWLINE) begin
                    has_cmd = 1'b1;
                    kind    = K_NEWLINE;
                end else if (glyph_ok) begin
                    has_cmd = 1'b1;
                    kind    = K_GLYPH;
                end
            end
            default: begin
                has_cmd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept && (s_in.operation == OP_LOAD) && load_ok) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (accept && has_cmd && (kind == K_GLYPH)) begin
            r_rd <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= has_cmd;
        end else if (o_q_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= kind;
            r_s1_pos_x <= s_in.pos_x;
            r_s1_pos_y <= s_in.pos_y;
        end
    end

    assign prod_x   = $signed(r_rd.off_x) * $signed({1'b0, i_cfg.scale});
    assign prod_y   = $signed(r_rd.off_y) * $signed({1'b0, i_cfg.scale});
    assign adv_prod = r_rd.adv * i_cfg.scale;

    assign o_q_data = '{
        kind:     r_s1_kind,
        pos_x:    r_s1_pos_x,
        pos_y:    r_s1_pos_y,
        prod_x:   prod_x,
        prod_y:   prod_y,
        adv_step: adv_prod[25:8],
        src_x:    r_rd.src_x,
        src_y:    r_rd.src_y,
        src_w:    r_rd.src_w,
        src_h:    r_rd.src_h
    };

endmodule
`default_nettype wire

>>> src/gfl_queue.sv
`default_nettype none
module gfl_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire gfl_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output gfl_pkg::t_cmd      o_data
);
    import gfl_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_cmd            r_buf [Q_DEPTH];
    logic [QAW-1:0]  r_wr_ptr;
    logic [QAW-1:0]  r_rd_ptr;
    logic [QCW-1:0]  r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == QCW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> src/gfl_back.sv
`default_nettype none
module gfl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gfl_pkg::t_cfg i_cfg,
    input  wire logic          i_q_valid,
    input  wire gfl_pkg::t_cmd i_q_data,
    output logic               o_q_pop,
    gfl_out_if.source          m_out
);
    import gfl_pkg::*;

    localparam logic signed [28:0] DMAX = 29'sd8388607;
    localparam logic signed [28:0] DMIN = -29'sd8388608;
    localparam logic signed [19:0] PMAX = 20'sd32767;
    localparam logic signed [19:0] PMIN = -20'sd32768;
    localparam logic signed [19:0] HMAX = 20'sd65535;
    localparam logic signed [19:0] HMIN = -20'sd65536;

    logic signed [15:0] r_origin_x;
    logic signed [15:0] r_origin_y;
    logic signed [15:0] r_pen_x;
    logic signed [15:0] r_pen_y;
    logic signed [15:0] r_widest_x;

    logic               r_out_valid;
    logic               r_kind;
    logic [23:0]        r_dest_x;
    logic [23:0]        r_dest_y;
    logic [11:0]        r_src_x;
    logic [11:0]        r_src_y;
    logic [11:0]        r_src_w;
    logic [11:0]        r_src_h;
    logic [31:0]        r_color;
    logic [16:0]        r_width;
    logic [16:0]        r_height;

    logic signed [15:0] widest_n;
    logic signed [28:0] dx_sum;
    logic signed [28:0] dy_sum;
    logic [23:0]        dx_sat;
    logic [23:0]        dy_sat;
    logic signed [19:0] px_sum;
    logic signed [19:0] py_sum;
    logic signed [15:0] px_sat;
    logic signed [15:0] py_sat;
    logic signed [19:0] h_sum;
    logic [16:0]        h_sat;
    logic [16:0]        w_val;
    logic               has_result;

    assign o_q_pop = i_q_valid && (!r_out_valid || m_out.ready);

    assign widest_n = (r_pen_x > r_widest_x) ? r_pen_x : r_widest_x;

    assign dx_sum = $signed({{5{r_pen_x[15]}}, r_pen_x, 8'd0})
                  + $signed({i_q_data.prod_x[27], i_q_data.prod_x});
    assign dy_sum = $signed({{5{r_pen_y[15]}}, r_pen_y, 8'd0})
                  + $signed({i_q_data.prod_y[27], i_q_data.prod_y});
    assign dx_sat = (dx_sum > DMAX) ? DMAX[23:0] : ((dx_sum < DMIN) ? DMIN[23:0] : dx_sum[23:0]);
    assign dy_sat = (dy_sum > DMAX) ? DMAX[23:0] : ((dy_sum < DMIN) ? DMIN[23:0] : dy_sum[23:0]);

    assign px_sum = $signed({{4{r_pen_x[15]}}, r_pen_x}) + $signed({2'b00, i_q_data.adv_step});
    assign py_sum = $signed({{4{r_pen_y[15]}}, r_pen_y}) + $signed({2'b00, i_cfg.line_step});
    assign px_sat = (px_sum > PMAX) ? PMAX[15:0] : ((px_sum < PMIN) ? PMIN[15:0] : px_sum[15:0]);
    assign py_sat = (py_sum > PMAX) ? PMAX[15:0] : ((py_sum < PMIN) ? PMIN[15:0] : py_sum[15:0]);

    assign h_sum = py_sum - $signed({{4{r_origin_y[15]}}, r_origin_y});
    assign h_sat = (h_sum > HMAX) ? HMAX[16:0] : ((h_sum < HMIN) ? HMIN[16:0] : h_sum[16:0]);
    assign w_val = {widest_n[15], widest_n} - {r_origin_x[15], r_origin_x};

    always_comb begin
        case (i_q_data.kind)
            K_GLYPH:  has_result = i_cfg.draw_en;
            K_FINISH: has_result = 1'b1;
            default:  has_result = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_widest_x  <= '0;
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= has_result;
            case (i_q_data.kind)
                K_START: begin
                    r_origin_x <= $signed(i_q_data.pos_x);
                    r_origin_y <= $signed(i_q_data.pos_y);
                    r_pen_x    <= $signed(i_q_data.pos_x);
                    r_pen_y    <= $signed(i_q_data.pos_y);
                    r_widest_x <= '0;
                end
                K_NEWLINE: begin
                    r_widest_x <= widest_n;
                    r_pen_x    <= r_origin_x;
                    r_pen_y    <= py_sat;
                end
                K_GLYPH: begin
                    r_pen_x <= px_sat;
                end
                K_FINISH: begin
                    r_widest_x <= widest_n;
                end
                default: begin
                    r_pen_x <= r_pen_x;
                end
            endcase
        end else if (m_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && has_result) begin
            if (i_q_data.kind == K_FINISH) begin
                r_kind   <= RK_DIMS;
                r_dest_x <= '0;
                r_dest_y <= '0;
                r_src_x  <= '0;
                r_src_y  <= '0;
                r_src_w  <= '0;
                r_src_h  <= '0;
                r_color  <= '0;
                r_width  <= w_val;
                r_height <= h_sat;
            end else begin
                r_kind   <= RK_BLIT;
                r_dest_x <= dx_sat;
                r_dest_y <= dy_sat;
                r_src_x  <= i_q_data.src_x;
                r_src_y  <= i_q_data.src_y;
                r_src_w  <= i_q_data.src_w;
                r_src_h  <= i_q_data.src_h;
                r_color  <= i_cfg.tint;
                r_width  <= '0;
                r_height <= '0;
            end
        end
    end

    assign m_out.valid       = r_out_valid;
    assign m_out.result_kind = r_kind;
    assign m_out.dest_x      = r_dest_x;
    assign m_out.dest_y      = r_dest_y;
    assign m_out.src_x       = r_src_x;
    assign m_out.src_y       = r_src_y;
    assign m_out.src_w       = r_src_w;
    assign m_out.src_h       = r_src_h;
    assign m_out.blit_color  = r_color;
    assign m_out.text_width  = r_width;
    assign m_out.text_height = r_height;

endmodule
`default_nettype wire

>>> src/bitmap_font_glyph_layout.sv
// Results are registered. Throughput: one item per cycle while the queue has room;
// the glyph table read and the scale multiplies sit in the front stage, the pen
// update loop (one add and saturate) in the back stage. A four-entry command queue
// lets input continue while a result waits on the output. Reset: synchronous,
// active low; clears control, pen state and configuration to defaults. The glyph
// table is not cleared and holds garbage until loaded.
`default_nettype none
module bitmap_font_glyph_layout (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    gfl_in_if.sink           s_in,
    gfl_out_if.source        m_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import gfl_pkg::*;

    localparam logic [1:0]  REG_SCALE  = 2'd0;
    localparam logic [1:0]  REG_LINE_H = 2'd1;
    localparam logic [1:0]  REG_DRAW   = 2'd2;
    localparam logic [1:0]  REG_TINT   = 2'd3;

    localparam logic [15:0] SCALE_RST  = 16'd256;
    localparam logic [9:0]  LINE_H_RST = 10'd16;
    localparam logic [25:0] LS_RST     = 26'(LINE_H_RST * SCALE_RST);

    logic [15:0] r_scale;
    logic [9:0]  r_line_h;
    logic        r_draw_en;
    logic [31:0] r_tint;
    logic [17:0] r_line_step;

    logic        cfg_wr;
    logic [25:0] ls_prod;
    t_cfg        cfg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    t_cmd        q_in;
    t_cmd        q_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign ls_prod = r_line_h * r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_RST;
            r_line_h    <= LINE_H_RST;
            r_draw_en   <= 1'b1;
            r_tint      <= 32'hFFFF_FFFF;
            r_line_step <= LS_RST[25:8];
        end else begin
            r_line_step <= ls_prod[25:8];
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_SCALE:  r_scale   <= pwdata[15:0];
                    REG_LINE_H: r_line_h  <= pwdata[9:0];
                    REG_DRAW:   r_draw_en <= pwdata[0];
                    REG_TINT:   r_tint    <= pwdata;
                    default:    r_tint    <= r_tint;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SCALE:  prdata = {16'd0, r_scale};
            REG_LINE_H: prdata = {22'd0, r_line_h};
            REG_DRAW:   prdata = {31'd0, r_draw_en};
            REG_TINT:   prdata = r_tint;
            default:    prdata = '0;
        endcase
    end

    assign cfg = '{
        scale:     r_scale,
        line_step: r_line_step,
        draw_en:   r_draw_en,
        tint:      r_tint
    };

    gfl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_in     (s_in),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    gfl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    gfl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .m_out     (m_out)
    );

    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_full |-> s_in.ready)
        else $error("input stalled while the command queue has room");

    a_out_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_out.valid) |-> $past(q_pop))
        else $error("result appeared without a queue pop");

    a_dims_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && (m_out.result_kind == RK_DIMS)) |->
            ((m_out.dest_x == '0) && (m_out.src_w == '0) && (m_out.blit_color == '0)))
        else $error("dimension result carries blit fields");

endmodule
`default_nettype wire

>>> verif/gfl_tb_pkg.sv
`timescale 1ns / 1ps
package gfl_tb_pkg;
    import gfl_pkg::*;

    localparam int REG_SCALE       = 0;
    localparam int REG_LINE_HEIGHT = 1;
    localparam int REG_DRAW_EN     = 2;
    localparam int REG_TINT        = 3;

    typedef struct {
        logic [1:0]         op;
        logic [7:0]         code;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [11:0]        src_x, src_y, src_w, src_h;
        logic signed [10:0] off_x, off_y;
        logic [9:0]         adv;
    } text_item_t;

    typedef struct {
        logic        kind;
        logic [23:0] dest_x, dest_y;
        logic [11:0] src_x, src_y, src_w, src_h;
        logic [31:0] color;
        logic [16:0] width, height;
    } text_result_t;

    typedef struct {
        logic [11:0] src_x, src_y, src_w, src_h;
        longint      off_x, off_y, adv;
    } glyph_entry_t;

    class glyph_layout_checker;
        longint         scale, line_h, tint;
        bit             draw_en;
        glyph_entry_t   glyphs[GLYPH_COUNT];
        longint         origin_x, origin_y, pen_x, pen_y, widest_x;
        text_result_t   pending_cmds[$];
        int             errors;

        function new();
            scale    = 256;
            line_h   = 16;
            draw_en  = 1'b1;
            tint     = 32'hFFFF_FFFF;
            origin_x = 0;
            origin_y = 0;
            pen_x    = 0;
            pen_y    = 0;
            widest_x = 0;
            errors   = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] value);
            case (idx)
                REG_SCALE:       scale = value[15:0];
                REG_LINE_HEIGHT: line_h = value[9:0];
                REG_DRAW_EN:     draw_en = value[0];
                REG_TINT:        tint = value;
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function longint line_step();
            return (line_h * scale) >> 8;
        endfunction

        function void accept_item(text_item_t it);
            text_result_t r;
            glyph_entry_t g;
            longint       dx, dy, w, h;
            int           idx;
            r = '{default: '0};
            idx = int'(it.code) - int'(CHAR_FIRST);
            case (it.op)
                OP_LOAD: begin
                    if (it.code < GLYPH_COUNT) begin
                        g.src_x = it.src_x;
                        g.src_y = it.src_y;
                        g.src_w = it.src_w;
                        g.src_h = it.src_h;
                        g.off_x = it.off_x;
                        g.off_y = it.off_y;
                        g.adv   = it.adv;
                        glyphs[it.code] = g;
                    end
                end
                OP_START: begin
                    origin_x = it.pos_x;
                    origin_y = it.pos_y;
                    pen_x    = origin_x;
                    pen_y    = origin_y;
                    widest_x = 0;
                end
                OP_FINISH: begin
                    if (pen_x > widest_x) widest_x = pen_x;
                    w = clamp(widest_x - origin_x, -65536, 65535);
                    h = clamp(pen_y + line_step() - origin_y, -65536, 65535);
                    r.kind   = RK_DIMS;
                    r.width  = w[16:0];
                    r.height = h[16:0];
                    pending_cmds.push_back(r);
                end
                default: begin
                    if (it.code == CHAR_NEWLINE) begin
                        if (pen_x > widest_x) widest_x = pen_x;
                        pen_x = origin_x;
                        pen_y = clamp(pen_y + line_step(), -32768, 32767);
                    end else if (idx >= 0 && idx < GLYPH_COUNT) begin
                        g = glyphs[idx];
                        if (draw_en) begin
                            dx = clamp(pen_x * 256 + g.off_x * scale, -8388608, 8388607);
                            dy = clamp(pen_y * 256 + g.off_y * scale, -8388608, 8388607);
                            r.kind   = RK_BLIT;
                            r.dest_x = dx[23:0];
                            r.dest_y = dy[23:0];
                            r.src_x  = g.src_x;
                            r.src_y  = g.src_y;
                            r.src_w  = g.src_w;
                            r.src_h  = g.src_h;
                            r.color  = tint[31:0];
                            pending_cmds.push_back(r);
                        end
                        pen_x = clamp(pen_x + ((g.adv * scale) >> 8), -32768, 32767);
                    end
                end
            endcase
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_command(text_result_t got);
            text_result_t want;
            if (pending_cmds.size() == 0) begin
                $display("%0t: result_kind expected none actual %h", $time, got.kind);
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            check_field("result_kind", want.kind, got.kind);
            check_field("dest_x", want.dest_x, got.dest_x);
            check_field("dest_y", want.dest_y, got.dest_y);
            check_field("src_x", want.src_x, got.src_x);
            check_field("src_y", want.src_y, got.src_y);
            check_field("src_w", want.src_w, got.src_w);
            check_field("src_h", want.src_h, got.src_h);
            check_field("blit_color", want.color, got.color);
            check_field("text_width", want.width, got.width);
            check_field("text_height", want.height, got.height);
        endfunction
    endclass

endpackage

>>> verif/bitmap_font_glyph_layout_tb.sv
`timescale 1ns / 1ps
module bitmap_font_glyph_layout_tb;
    import gfl_pkg::*;
    import gfl_tb_pkg::*;

    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS = 242;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gfl_in_if  in_if();
    gfl_out_if out_if();

    bitmap_font_glyph_layout DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (in_if),
        .m_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    glyph_layout_checker chk;
    int                  tx_idle_pct;
    int                  rx_stall_pct;
    logic [7:0]          hold_token;
    int                  loaded_idx[$];
    bit                  glyph_loaded[GLYPH_COUNT];
    int                  counted;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("bitmap_font_glyph_layout_tb failed");
        $finish;
    end

    initial begin : receiver
        int         hold_left;
        logic [7:0] hold_seen;
        hold_left = 0;
        hold_seen = 8'd0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        text_result_t r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            r.kind   = out_if.result_kind;
            r.dest_x = out_if.dest_x;
            r.dest_y = out_if.dest_y;
            r.src_x  = out_if.src_x;
            r.src_y  = out_if.src_y;
            r.src_w  = out_if.src_w;
            r.src_h  = out_if.src_h;
            r.color  = out_if.blit_color;
            r.width  = out_if.text_width;
            r.height = out_if.text_height;
            chk.check_command(r);
        end
    end

    function automatic text_item_t noise_item(logic [1:0] op, logic [7:0] code);
        text_item_t it;
        it.op    = op;
        it.code  = code;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.src_x = $urandom;
        it.src_y = $urandom;
        it.src_w = $urandom;
        it.src_h = $urandom;
        it.off_x = $urandom;
        it.off_y = $urandom;
        it.adv   = $urandom;
        return it;
    endfunction

    function automatic text_item_t make_load(logic [7:0] idx);
        text_item_t it;
        it = noise_item(OP_LOAD, idx);
        if ($urandom_range(0, 1) == 0) begin
            it.off_x = $urandom_range(0, 16) - 8;
            it.off_y = $urandom_range(0, 16) - 8;
            it.adv   = $urandom_range(0, 24);
        end
        if (idx < GLYPH_COUNT && !glyph_loaded[idx]) begin
            glyph_loaded[idx] = 1'b1;
            loaded_idx.push_back(idx);
        end
        return it;
    endfunction

    function automatic text_item_t make_start();
        text_item_t it;
        it = noise_item(OP_START, $urandom);
        if ($urandom_range(0, 1) == 0) begin
            it.pos_x = $urandom_range(0, 400) - 200;
            it.pos_y = $urandom_range(0, 400) - 200;
        end
        return it;
    endfunction

    function automatic logic [7:0] pick_char();
        int         roll;
        logic [7:0] c;
        roll = $urandom_range(0, 99);
        if (roll < 75 && loaded_idx.size() > 0)
            return 8'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)] + CHAR_FIRST);
        if (roll < 88)
            return CHAR_NEWLINE;
        if (roll < 94) begin
            c = $urandom_range(0, 31);
            return (c == CHAR_NEWLINE) ? 8'd0 : c;
        end
        return $urandom_range(127, 255);
    endfunction

    function automatic bit is_ignored(text_item_t it);
        if (it.op == OP_LOAD)
            return it.code >= GLYPH_COUNT;
        if (it.op == OP_CHAR)
            return it.code != CHAR_NEWLINE &&
                   (it.code < CHAR_FIRST || it.code >= CHAR_FIRST + GLYPH_COUNT);
        return 1'b0;
    endfunction

    task automatic send_item(input text_item_t it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.operation     <= it.op;
        in_if.char_code     <= it.code;
        in_if.pos_x         <= it.pos_x;
        in_if.pos_y         <= it.pos_y;
        in_if.glyph_src_x   <= it.src_x;
        in_if.glyph_src_y   <= it.src_y;
        in_if.glyph_width   <= it.src_w;
        in_if.glyph_height  <= it.src_h;
        in_if.glyph_off_x   <= it.off_x;
        in_if.glyph_off_y   <= it.off_y;
        in_if.glyph_advance <= it.adv;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        chk.accept_item(it);
        if (!is_ignored(it)) counted++;
    endtask

    task automatic send_char(logic [7:0] code);
        send_item(noise_item(OP_CHAR, code));
    endtask

    task automatic send_start(logic signed [15:0] x, logic signed [15:0] y);
        text_item_t it;
        it = make_start();
        it.pos_x = x;
        it.pos_y = y;
        send_item(it);
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (chk.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apb_write(int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        chk.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] s, logic [9:0] lh, logic de, logic [31:0] tint);
        wait_idle();
        apb_write(REG_SCALE, s);
        apb_write(REG_LINE_HEIGHT, lh);
        apb_write(REG_DRAW_EN, de);
        apb_write(REG_TINT, tint);
    endtask

    task automatic run_text(int n_items);
        int target;
        int roll;
        target = counted + n_items;
        while (counted < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 8 || loaded_idx.size() < 8) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(make_load($urandom_range(0, 255)));
                else
                    send_item(make_load($urandom_range(0, GLYPH_COUNT + 3)));
            end else if (roll < 85) begin
                send_item(make_start());
                repeat ($urandom_range(0, 16)) send_char(pick_char());
                send_item(noise_item(OP_FINISH, $urandom));
            end else begin
                case ($urandom_range(0, 2))
                    0: send_item(make_start());
                    1: send_char(pick_char());
                    default: send_item(noise_item(OP_FINISH, $urandom));
                endcase
            end
        end
    endtask

    initial begin
        text_item_t it;
        chk                 = new();
        counted             = 0;
        tx_idle_pct         = 9;
        rx_stall_pct        = 58;
        hold_token          = 8'd0;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_if.valid         = 1'b0;
        in_if.operation     = OP_LOAD;
        in_if.char_code     = '0;
        in_if.pos_x         = '0;
        in_if.pos_y         = '0;
        in_if.glyph_src_x   = '0;
        in_if.glyph_src_y   = '0;
        in_if.glyph_width   = '0;
        in_if.glyph_height  = '0;
        in_if.glyph_off_x   = '0;
        in_if.glyph_off_y   = '0;
        in_if.glyph_advance = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        it = make_load(8'd0);
        it.src_x = '1;
        it.src_y = '1;
        it.src_w = '1;
        it.src_h = '1;
        it.off_x = -11'sd1024;
        it.off_y = 11'sd1023;
        it.adv   = '1;
        send_item(it);
        it = make_load(8'(GLYPH_COUNT - 1));
        it.src_x = '0;
        it.src_y = '0;
        it.src_w = '0;
        it.src_h = '0;
        it.off_x = 11'sd1023;
        it.off_y = -11'sd1024;
        it.adv   = '0;
        send_item(it);
        send_item(make_load(8'd33));
        send_item(make_load(8'(GLYPH_COUNT)));
        send_item(make_load(8'hFF));
        send_start(-16'sd32768, 16'sd32767);
        send_char(CHAR_FIRST);
        send_char(8'(CHAR_FIRST + GLYPH_COUNT - 1));
        send_char(CHAR_FIRST + 8'd33);
        send_char(CHAR_NEWLINE);
        send_char(8'd0);
        send_char(8'd31);
        send_char(8'd127);
        send_char(8'd255);
        send_char(CHAR_FIRST + 8'd33);
        send_item(noise_item(OP_FINISH, $urandom));
        send_start(16'sd32767, -16'sd32768);
        send_char(CHAR_FIRST);
        send_char(CHAR_NEWLINE);
        send_item(noise_item(OP_FINISH, $urandom));
        send_start(-16'sd100, 16'sd0);
        send_item(noise_item(OP_FINISH, $urandom));
        send_start(16'sd0, 16'sd0);
        send_char(8'(CHAR_FIRST + GLYPH_COUNT - 1));
        send_item(noise_item(OP_FINISH, $urandom));

        configure(16'hFFFF, 10'h3FF, 1'b1, 32'h0);
        run_text(PHASE_ITEMS);
        configure(16'h0, 10'h0, 1'b0, 32'hFFFF_FFFF);
        run_text(PHASE_ITEMS);

        tx_idle_pct = 58;
        rx_stall_pct <= 9;
        configure(16'd256, 10'd16, 1'b1, $urandom);
        run_text(PHASE_ITEMS);
        configure($urandom_range(64, 1024), $urandom, 1'b1, $urandom);
        run_text(PHASE_ITEMS);

        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        configure(16'd128, 10'd8, 1'b1, $urandom);
        hold_token <= hold_token + 8'd1;
        run_text(PHASE_ITEMS);
        configure($urandom, $urandom, 1'b1, $urandom);
        hold_token <= hold_token + 8'd1;
        run_text(PHASE_ITEMS);

        wait_idle();
        if (chk.errors == 0 && chk.pending_cmds.size() == 0) begin
            $display("bitmap_font_glyph_layout_tb passed");
        end else begin
            $display("bitmap_font_glyph_layout_tb failed");
        end
        $finish;
    end

endmodule
